[rtl/imp_pkg.sv]
package imp_pkg;

	localparam int CORDIC_STAGES       = 24;
	localparam int PHASE_FRACTION_BITS = 16;
	localparam int TABLE_SIZE          = 32;
	localparam int ANGLE_FRAC          = 32;
	localparam int GUARD_BITS          = 16;

	localparam int IN_W    = 32;
	localparam int MAG_W   = 32;
	localparam int PHASE_W = 25;

	localparam int CS = (CORDIC_STAGES > TABLE_SIZE) ? TABLE_SIZE : CORDIC_STAGES;
	localparam int FB = (PHASE_FRACTION_BITS > ANGLE_FRAC) ? ANGLE_FRAC : PHASE_FRACTION_BITS;

	localparam int X_W     = IN_W + 1 + GUARD_BITS + 3;
	localparam int ANGLE_W = ANGLE_FRAC + 6;
	localparam int Z_W     = ANGLE_FRAC + 9;
	localparam int SQ_W    = 2 * IN_W;
	localparam int T_W     = 64;

	localparam int ISQ_STAGES = MAG_W;
	localparam int MAG_LAT    = 3 + ISQ_STAGES;
	localparam int PH_LAT     = 2 + CS;
	localparam int PAD        = MAG_LAT - PH_LAT;
	localparam int LAT        = MAG_LAT;

	localparam logic [63:0] PI_Q56 = 64'h03243F6A8885A308;

	localparam logic signed [T_W-1:0] T_OFFSET = T_W'(64'd180 << ANGLE_FRAC);
	localparam logic signed [T_W-1:0] T_LO     = T_W'(64'd90 << ANGLE_FRAC);
	localparam logic signed [T_W-1:0] T_HI     = T_W'(64'd270 << ANGLE_FRAC);

	localparam logic [PHASE_W-1:0] PH_90  = PHASE_W'(64'd90 << FB);
	localparam logic [PHASE_W-1:0] PH_180 = PHASE_W'(64'd180 << FB);
	localparam logic [PHASE_W-1:0] PH_270 = PHASE_W'(64'd270 << FB);

	typedef logic [ANGLE_W-1:0] angle_t;
	typedef angle_t [TABLE_SIZE-1:0] angle_table_t;

	typedef struct packed {
		logic zero;
		logic re_zero;
		logic im_pos;
	} ph_flags_t;

	function automatic logic [127:0] udiv_const(input logic [127:0] num, input logic [63:0] den);
		logic [127:0] q;
		logic [64:0]  r;
		q = '0;
		r = '0;
		for (int b = 127; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r    = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] atan_rad_q56(input int k);
		logic [63:0]  pos;
		logic [63:0]  neg;
		logic [127:0] qt;
		int           e;
		pos = '0;
		neg = '0;
		for (int n = 0; n < 64; n++) begin
			e = 56 - k * (2 * n + 1);
			if (e >= 0) begin
				qt = udiv_const(128'(1) << e, 64'(2 * n + 1));
				if ((n % 2) == 0) begin
					pos = pos + qt[63:0];
				end else begin
					neg = neg + qt[63:0];
				end
			end
		end
		return pos - neg;
	endfunction

	function automatic angle_t rad_q56_to_deg_q32(input logic [63:0] a);
		logic [63:0]  num;
		logic [127:0] qt;
		num = a * 64'd180;
		qt  = udiv_const({32'b0, num, 32'b0}, PI_Q56);
		return qt[ANGLE_W-1:0];
	endfunction

	function automatic angle_table_t build_angle_table();
		angle_table_t t;
		t[0] = ANGLE_W'(64'd45 << ANGLE_FRAC);
		for (int k = 1; k < TABLE_SIZE; k++) begin
			t[k] = rad_q56_to_deg_q32(atan_rad_q56(k));
		end
		return t;
	endfunction

	localparam angle_table_t ATAN_DEG = build_angle_table();

endpackage

[rtl/impedance_magnitude_phase_top.sv]
// Channel  | Signals                                   | Transfer
// ---------+-------------------------------------------+------------------------------
// request  | start, busy, real_part, imag_part         | start && !busy at clock edge
// result   | strobe, magnitude, phase_deg_q16, both_zero | strobe high for one cycle
//
// One transaction enters per cycle; busy stays low.
// The result is registered through abs, square, sum, then 32
// one-bit square root stages; the CORDIC path (fold, 24 stages, clamp) is
// delayed to match.
// arst_n clears all valid bits; results still in flight are dropped.
// The receiver cannot stall, so the pipeline advances every cycle.
module impedance_magnitude_phase_top import imp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [IN_W-1:0] real_part,
	input  logic signed [IN_W-1:0] imag_part,
	output logic                   strobe,
	output logic [MAG_W-1:0]       magnitude,
	output logic [PHASE_W-1:0]     phase_deg_q16,
	output logic                   both_zero
);

	logic             accept;
	logic [LAT-1:0]   vld_s;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-2:0], accept};
		end
	end

	assign strobe = vld_s[LAT-1];

	logic signed [IN_W:0]   re_ext;
	logic signed [IN_W:0]   im_ext;
	logic signed [IN_W:0]   re_f;
	logic signed [IN_W:0]   im_f;
	logic [IN_W-1:0]        ar_c;
	logic [IN_W-1:0]        ai_c;
	ph_flags_t              fl_c;

	assign re_ext = {real_part[IN_W-1], real_part};
	assign im_ext = {imag_part[IN_W-1], imag_part};
	assign re_f   = real_part[IN_W-1] ? -re_ext : re_ext;
	assign im_f   = real_part[IN_W-1] ? -im_ext : im_ext;
	assign ar_c   = real_part[IN_W-1] ? -real_part : real_part;
	assign ai_c   = imag_part[IN_W-1] ? -imag_part : imag_part;

	assign fl_c.zero    = (real_part == '0) && (imag_part == '0);
	assign fl_c.re_zero = (real_part == '0);
	assign fl_c.im_pos  = ~imag_part[IN_W-1] && (imag_part != '0);

	logic [IN_W-1:0]        ar_s1;
	logic [IN_W-1:0]        ai_s1;
	logic signed [X_W-1:0]  cx_s [CS+1];
	logic signed [X_W-1:0]  cy_s [CS+1];
	logic signed [Z_W-1:0]  cz_s [CS+1];
	ph_flags_t              fl_s [CS+1];

	always_ff @(posedge clk) begin
		ar_s1   <= ar_c;
		ai_s1   <= ai_c;
		cx_s[0] <= {{(X_W-IN_W-1-GUARD_BITS){re_f[IN_W]}}, re_f, {GUARD_BITS{1'b0}}};
		cy_s[0] <= {{(X_W-IN_W-1-GUARD_BITS){im_f[IN_W]}}, im_f, {GUARD_BITS{1'b0}}};
		cz_s[0] <= '0;
		fl_s[0] <= fl_c;
	end

	logic [SQ_W-1:0] sq_r_s2;
	logic [SQ_W-1:0] sq_i_s2;
	logic [SQ_W-1:0] sum_s3;

	always_ff @(posedge clk) begin
		sq_r_s2 <= SQ_W'(ar_s1) * SQ_W'(ar_s1);
		sq_i_s2 <= SQ_W'(ai_s1) * SQ_W'(ai_s1);
		sum_s3  <= sq_r_s2 + sq_i_s2;
	end

	logic [SQ_W-1:0] rem_s  [ISQ_STAGES+1];
	logic [SQ_W-1:0] root_s [ISQ_STAGES+1];

	assign rem_s[0]  = sum_s3;
	assign root_s[0] = '0;

	for (genvar j = 1; j <= ISQ_STAGES; j++) begin : g_isqrt
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ISQ_STAGES - j));
		logic [SQ_W-1:0] trial;
		assign trial = root_s[j-1] + BIT;
		always_ff @(posedge clk) begin
			if (rem_s[j-1] >= trial) begin
				rem_s[j]  <= rem_s[j-1] - trial;
				root_s[j] <= (root_s[j-1] >> 1) + BIT;
			end else begin
				rem_s[j]  <= rem_s[j-1];
				root_s[j] <= root_s[j-1] >> 1;
			end
		end
	end

	assign magnitude = root_s[ISQ_STAGES][MAG_W-1:0];

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_DEG[i]);
		logic signed [X_W-1:0] xs;
		logic signed [X_W-1:0] ys;
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;
		always_ff @(posedge clk) begin
			fl_s[i+1] <= fl_s[i];
			if (!cy_s[i][X_W-1]) begin
				cx_s[i+1] <= cx_s[i] + ys;
				cy_s[i+1] <= cy_s[i] - xs;
				cz_s[i+1] <= cz_s[i] + ANG;
			end else begin
				cx_s[i+1] <= cx_s[i] - ys;
				cy_s[i+1] <= cy_s[i] + xs;
				cz_s[i+1] <= cz_s[i] - ANG;
			end
		end
	end

	logic signed [T_W-1:0] t_c;
	logic signed [T_W-1:0] t_clamp;
	logic [T_W-1:0]        t_u;
	logic [PHASE_W-1:0]    phase_c;

	always_comb begin
		t_c = T_W'(cz_s[CS]) + T_OFFSET;
		if (t_c < T_LO) begin
			t_clamp = T_LO;
		end else if (t_c > T_HI) begin
			t_clamp = T_HI;
		end else begin
			t_clamp = t_c;
		end
		t_u = t_clamp;
		if (fl_s[CS].zero) begin
			phase_c = PH_180;
		end else if (fl_s[CS].re_zero) begin
			phase_c = fl_s[CS].im_pos ? PH_270 : PH_90;
		end else begin
			phase_c = t_u[ANGLE_FRAC-FB +: PHASE_W];
		end
	end

	logic [PHASE_W-1:0] ph_dly_s [PAD+1];
	logic               bz_dly_s [PAD+1];

	always_ff @(posedge clk) begin
		ph_dly_s[0] <= phase_c;
		bz_dly_s[0] <= fl_s[CS].zero;
	end

	for (genvar k = 1; k <= PAD; k++) begin : g_align
		always_ff @(posedge clk) begin
			ph_dly_s[k] <= ph_dly_s[k-1];
			bz_dly_s[k] <= bz_dly_s[k-1];
		end
	end

	assign phase_deg_q16 = ph_dly_s[PAD];
	assign both_zero     = bz_dly_s[PAD];

endmodule

[rtl/imp_checker.sv]
module imp_checker import imp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic signed [IN_W-1:0] real_part,
	input logic signed [IN_W-1:0] imag_part,
	input logic                   strobe,
	input logic [MAG_W-1:0]       magnitude,
	input logic [PHASE_W-1:0]     phase_deg_q16,
	input logic                   both_zero
);

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (phase_deg_q16 >= PH_90) && (phase_deg_q16 <= PH_270))
		else $error("phase outside the 90 to 270 degree range");

	a_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && both_zero |-> (magnitude == '0) && (phase_deg_q16 == PH_180))
		else $error("zero point with nonzero magnitude or phase other than 180");

	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (magnitude == '0) |-> both_zero)
		else $error("zero magnitude without zero flag");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT strobe)
		else $error("accepted transaction produced no result strobe");

	a_origin_flag: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (real_part == '0) && (imag_part == '0) |-> ##LAT both_zero)
		else $error("origin transaction returned without zero flag");

endmodule

bind impedance_magnitude_phase_top imp_checker u_imp_checker (.*);
